[hdl/assert_macros.svh]
// assertion macros shared by the shadow write queue modules
// no dependencies; the checks drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// condition that must hold at every clock edge outside reset
`define CHK_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed");
// consequence in the same cycle
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// consequence in the following cycle
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_ALWAYS(lbl, clk, rst, cond)
`define CHK_IMPLY(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/drsq_pkg.sv]
// shared types and constants of the display register shadow write queue
// no dependencies; imported by the controller, datapath and top modules
package drsq_pkg;

  localparam int NUM_REGS_DEF = 48;

  // field widths
  localparam int FUNC_W = 3;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int LINE_W = 8;

  // stream widths
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;
  localparam int M_PAD_W   = M_TDATA_W - IDX_W - 2 * VAL_W;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_SET      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_BITS = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLR_BITS = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_GET      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd5;

  // result kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // special registers
  localparam logic [IDX_W-1:0] MERGE_IDX  = 6'd2;
  localparam logic [IDX_W-1:0] LIVE_IDX_A = 6'd2;
  localparam logic [IDX_W-1:0] LIVE_IDX_B = 6'd3;
  localparam logic [VAL_W-1:0] MERGE_MASK = 16'hFFE7;

  // vertical blank window, end exclusive
  localparam logic [LINE_W-1:0] VBLANK_FIRST = 8'd161;
  localparam logic [LINE_W-1:0] VBLANK_END   = 8'd225;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the item, read shadow at its index
    logic clear_all;   // zero shadow and empty the queue
    logic modify;      // update shadow, emit or queue
    logic get;         // build the read result
    logic list_rd;     // read queue entry at the flush pointer
    logic shadow_rd;   // read shadow at the queue entry
    logic flush_res;   // build the flush write result
    logic push;        // move the result into the output register
    logic flush_step;  // advance the flush pointer
    logic flush_done;  // empty the queue after the last entry
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_range;    // index of the offered item is below the register count
    logic blank;       // captured item falls in vertical or forced blank
    logic count_zero;  // queue is empty
    logic flush_last;  // flush pointer is at the last queued entry
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

[hdl/drsq_ram.sv]
// generic simple dual port ram with registered read
// no dependencies
module drsq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/drsq_ctrl.sv]
// controller state machine of the shadow write queue
// depends on drsq_pkg and assert_macros.svh
`include "assert_macros.svh"

module drsq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [drsq_pkg::FUNC_W-1:0] in_func,
  output logic                        in_ready,
  input  drsq_pkg::status_t           sts,
  output drsq_pkg::cmd_t              cmd
);

  import drsq_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_MODIFY    = 3'd1;
  localparam logic [2:0] ST_GET       = 3'd2;
  localparam logic [2:0] ST_EMIT      = 3'd3;
  localparam logic [2:0] ST_FL_LIST   = 3'd4;
  localparam logic [2:0] ST_FL_SHADOW = 3'd5;
  localparam logic [2:0] ST_FL_RES    = 3'd6;
  localparam logic [2:0] ST_FL_EMIT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (in_func inside {FUNC_SET, FUNC_SET_BITS, FUNC_CLR_BITS}) begin
            if (sts.in_range) begin
              state_next = ST_MODIFY;
            end
          end else if (in_func == FUNC_GET) begin
            state_next = ST_GET;
          end else if (in_func == FUNC_FLUSH) begin
            if (!sts.count_zero) begin
              state_next = ST_FL_LIST;
            end
          end else if (in_func == FUNC_CLEAR) begin
            cmd.clear_all = 1'b1;
          end
        end
      end
      ST_MODIFY: begin
        cmd.modify = 1'b1;
        state_next = sts.blank ? ST_EMIT : ST_IDLE;
      end
      ST_GET: begin
        cmd.get    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FL_LIST: begin
        cmd.list_rd = 1'b1;
        state_next  = ST_FL_SHADOW;
      end
      ST_FL_SHADOW: begin
        cmd.shadow_rd = 1'b1;
        state_next    = ST_FL_RES;
      end
      ST_FL_RES: begin
        cmd.flush_res = 1'b1;
        state_next    = ST_FL_EMIT;
      end
      ST_FL_EMIT: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          if (sts.flush_last) begin
            cmd.flush_done = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            cmd.flush_step = 1'b1;
            state_next     = ST_FL_LIST;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a flush never walks an empty queue
  `CHK_IMPLY(a_flush_nonempty, clk, rst, state == ST_FL_LIST, !sts.count_zero)
  // clear all empties the queue at once
  `CHK_NEXT(a_clear_empties, clk, rst, accept && in_func == FUNC_CLEAR, sts.count_zero)
  // the last flush entry leaves an empty queue and an idle controller
  `CHK_NEXT(a_flush_ends, clk, rst, state == ST_FL_EMIT && sts.out_free && sts.flush_last, state == ST_IDLE && sts.count_zero)

endmodule

[hdl/drsq_dp.sv]
// datapath of the shadow write queue: shadow ram, queue ram, flags, output register
// depends on drsq_pkg, drsq_ram and assert_macros.svh
`include "assert_macros.svh"

module drsq_dp #(
  parameter int NUM_REGS = drsq_pkg::NUM_REGS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  drsq_pkg::cmd_t              cmd,
  output drsq_pkg::status_t           sts,
  input  logic [drsq_pkg::FUNC_W-1:0] in_func,
  input  logic [drsq_pkg::IDX_W-1:0]  in_index,
  input  logic [drsq_pkg::VAL_W-1:0]  in_data,
  input  logic [drsq_pkg::LINE_W-1:0] in_scanline,
  input  logic                        in_fblank,
  input  logic [drsq_pkg::VAL_W-1:0]  in_live,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [drsq_pkg::IDX_W-1:0]  out_index,
  output logic [drsq_pkg::VAL_W-1:0]  out_value,
  output logic [drsq_pkg::VAL_W-1:0]  out_mask,
  output logic                        out_last
);

  import drsq_pkg::*;

  localparam int AW = $clog2(NUM_REGS);
  localparam int CW = $clog2(NUM_REGS + 1);
  localparam logic [IDX_W:0] REG_LIMIT = (IDX_W + 1)'(NUM_REGS);
  localparam logic [CW-1:0]  CNT_LIMIT = CW'(NUM_REGS);

  // captured item
  logic [FUNC_W-1:0] it_func;
  logic [IDX_W-1:0]  it_index;
  logic [VAL_W-1:0]  it_data;
  logic [LINE_W-1:0] it_scanline;
  logic              it_fblank;
  logic [VAL_W-1:0]  it_live;
  logic              it_in_range;

  // shadow storage
  logic [NUM_REGS-1:0] sh_valid;
  logic                sh_valid_q;
  logic                sh_re;
  logic [AW-1:0]       sh_raddr;
  logic [VAL_W-1:0]    sh_rdata;
  logic [VAL_W-1:0]    sh_old;
  logic [VAL_W-1:0]    new_val;
  logic [VAL_W-1:0]    get_val;

  // queue
  logic [CW-1:0]       pend_count;
  logic [NUM_REGS-1:0] pend_flags;
  logic [AW-1:0]       flush_ptr;
  logic                list_we;
  logic [IDX_W-1:0]    list_rdata;
  logic [IDX_W-1:0]    fl_index;
  logic                blank;
  logic                flush_last;

  // pending result
  logic             res_kind;
  logic [IDX_W-1:0] res_index;
  logic [VAL_W-1:0] res_value;
  logic [VAL_W-1:0] res_mask;
  logic             res_last;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_func     <= in_func;
      it_index    <= in_index;
      it_data     <= in_data;
      it_scanline <= in_scanline;
      it_fblank   <= in_fblank;
      it_live     <= in_live;
      it_in_range <= sts.in_range;
    end
  end

  // shadow ram and its written flags
  assign sh_re    = cmd.capture || cmd.shadow_rd;
  assign sh_raddr = cmd.capture ? in_index[AW-1:0] : list_rdata[AW-1:0];

  drsq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NUM_REGS)
  ) u_shadow (
    .clk   (clk),
    .we    (cmd.modify),
    .waddr (it_index[AW-1:0]),
    .wdata (new_val),
    .re    (sh_re),
    .raddr (sh_raddr),
    .rdata (sh_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      sh_valid <= '0;
    end else if (cmd.modify) begin
      sh_valid[it_index[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sh_re) begin
      sh_valid_q <= sh_valid[sh_raddr];
    end
  end

  // an entry never written since reset or clear reads as zero
  assign sh_old = sh_valid_q ? sh_rdata : '0;

  // shadow update
  always_comb begin
    case (it_func)
      FUNC_SET:      new_val = it_data;
      FUNC_SET_BITS: new_val = sh_old | it_data;
      FUNC_CLR_BITS: new_val = sh_old & ~it_data;
      default:       new_val = sh_old;
    endcase
  end

  // read value, live hardware value for the two status registers
  always_comb begin
    if (it_index == LIVE_IDX_A || it_index == LIVE_IDX_B) begin
      get_val = it_live;
    end else if (it_in_range) begin
      get_val = sh_old;
    end else begin
      get_val = '0;
    end
  end

  assign blank = (it_scanline >= VBLANK_FIRST && it_scanline < VBLANK_END) || it_fblank;

  // queue append outside blank, once per index
  assign list_we = cmd.modify && !blank && !pend_flags[it_index[AW-1:0]]
                   && (pend_count < CNT_LIMIT);

  drsq_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_REGS)
  ) u_list (
    .clk   (clk),
    .we    (list_we),
    .waddr (pend_count[AW-1:0]),
    .wdata (it_index),
    .re    (cmd.list_rd),
    .raddr (flush_ptr),
    .rdata (list_rdata)
  );

  // queue count, flags and flush pointer
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all || cmd.flush_done) begin
      pend_count <= '0;
      pend_flags <= '0;
      flush_ptr  <= '0;
    end else begin
      if (list_we) begin
        pend_count                   <= pend_count + CW'(1);
        pend_flags[it_index[AW-1:0]] <= 1'b1;
      end
      if (cmd.flush_step) begin
        flush_ptr <= flush_ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shadow_rd) begin
      fl_index <= list_rdata;
    end
  end

  assign flush_last = (CW'(flush_ptr) + CW'(1)) == pend_count;

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.modify) begin
      res_kind  <= KIND_WRITE;
      res_index <= it_index;
      res_value <= new_val;
      res_mask  <= (it_index == MERGE_IDX) ? MERGE_MASK : '0;
      res_last  <= 1'b1;
    end else if (cmd.get) begin
      res_kind  <= KIND_READ;
      res_index <= it_index;
      res_value <= get_val;
      res_mask  <= '0;
      res_last  <= 1'b1;
    end else if (cmd.flush_res) begin
      res_kind  <= KIND_WRITE;
      res_index <= fl_index;
      res_value <= sh_old;
      res_mask  <= (fl_index == MERGE_IDX) ? MERGE_MASK : '0;
      res_last  <= flush_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_kind  <= res_kind;
      out_index <= res_index;
      out_value <= res_value;
      out_mask  <= res_mask;
      out_last  <= res_last;
    end
  end

  // status
  assign sts.in_range   = {1'b0, in_index} < REG_LIMIT;
  assign sts.blank      = blank;
  assign sts.count_zero = (pend_count == '0);
  assign sts.flush_last = flush_last;
  assign sts.out_free   = !out_valid || out_ready;

  // the queue never holds more entries than registers
  `CHK_ALWAYS(a_count_bound, clk, rst, pend_count <= CNT_LIMIT)
  // one flag per queued entry
  `CHK_ALWAYS(a_flags_match, clk, rst, $countones(pend_flags) == int'(pend_count))
  // a merge mask only rides on writes to the merge register
  `CHK_IMPLY(a_mask_idx, clk, rst, out_valid && out_mask != '0, out_kind == KIND_WRITE && out_index == MERGE_IDX)

endmodule

[hdl/display_register_shadow_write_queue_top.sv]
// top level of the display register shadow write queue
// depends on drsq_pkg, drsq_ctrl, drsq_dp and drsq_ram
//
// Usage: register accesses enter on the s_ stream, one transaction per access;
// s_tuser carries the function code. Hardware writes and get read data leave on
// the m_ stream; m_tuser marks a write (0) or read data (1), m_tlast closes the
// results of one access.
// Sequence: set, set bits and clear bits pass through accept and shadow update;
// in blank a further step loads the write into the output register. A get
// passes through accept, read result build and output load. A flush passes
// through accept and then, per queued entry, queue ram read, shadow ram read,
// result build and output load; clear all and an empty flush end at
// acceptance. The shadow and queue rams each have one read port, which is why
// each flush entry reads them in separate steps.
// The next access is accepted as soon as the controller is back to idle, even
// while a result still sits in the output register.
// Reset: synchronous; shadow written flags, queue count and flags are cleared
// at once, so the shadow reads as zero; no clearing pass is run.
// Stall: when m_tready is low the output register holds and the controller
// waits before loading the next result; no result is lost.
module display_register_shadow_write_queue_top #(
  parameter int NUM_REGS = drsq_pkg::NUM_REGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // reg_index, data, scanline, forced_blank, live_value, zero pad
  input  logic [drsq_pkg::S_TDATA_W-1:0] s_tdata,
  // func
  input  logic [drsq_pkg::FUNC_W-1:0]    s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_index, out_value, merge_mask, zero pad
  output logic [drsq_pkg::M_TDATA_W-1:0] m_tdata,
  // kind
  output logic [0:0]                     m_tuser,
  output logic                           m_tlast
);

  import drsq_pkg::*;

  cmd_t             cmd;
  status_t          sts;
  logic             out_kind;
  logic [IDX_W-1:0] out_index;
  logic [VAL_W-1:0] out_value;
  logic [VAL_W-1:0] out_mask;

  // controller
  drsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath, input fields unpacked from tdata
  drsq_dp #(
    .NUM_REGS (NUM_REGS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_func     (s_tuser),
    .in_index    (s_tdata[5:0]),
    .in_data     (s_tdata[21:6]),
    .in_scanline (s_tdata[29:22]),
    .in_fblank   (s_tdata[30]),
    .in_live     (s_tdata[46:31]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (out_kind),
    .out_index   (out_index),
    .out_value   (out_value),
    .out_mask    (out_mask),
    .out_last    (m_tlast)
  );

  // result packing
  assign m_tdata = {{M_PAD_W{1'b0}}, out_mask, out_value, out_index};
  assign m_tuser = out_kind;

endmodule
